>>> hdl/eden_region_bump_allocator_defines.svh
// Assertion helpers used by the checker file.
`ifndef EDEN_REGION_BUMP_ALLOCATOR_DEFINES_SVH
`define EDEN_REGION_BUMP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled during reset
`define ERBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled during reset
`define ERBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/erba_pkg.sv
`default_nettype none

package erba_pkg;

    // Sizing
    localparam int MAX_REGIONS = 64;
    localparam int OFFSET_BITS = 20;
    localparam int REGION_BITS = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int COUNT_BITS  = $clog2(MAX_REGIONS + 1);
    localparam int BYTES_W     = 21;
    localparam int OBJ_W       = 32;
    localparam int CFG_SMALL_W = 7;

    // Result status codes
    localparam logic [1:0] ST_GRANTED = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_TOOBIG  = 2'd2;
    localparam logic [1:0] ST_NOROOM  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_REGION_BYTES   = 2'd0;
    localparam logic [1:0] CFG_REGIONS_IN_USE = 2'd1;
    localparam logic [1:0] CFG_EDEN_LIMIT     = 2'd2;

    // Configuration reset values
    localparam logic [BYTES_W-1:0]     RST_REGION_BYTES   = 21'd65536;
    localparam logic [CFG_SMALL_W-1:0] RST_REGIONS_IN_USE = 7'd64;
    localparam logic [CFG_SMALL_W-1:0] RST_EDEN_LIMIT     = 7'd16;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_size;
        logic       scan_start;
        logic       issue;
        logic       fresh_rd;
        logic       grant;
        logic       grant_new;
        logic       finish;
        logic [1:0] fin_status;
    } erba_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic size_zero;
        logic size_big;
        logic more;
        logic pipe_empty;
        logic hit;
        logic fresh_ok;
    } erba_stat_t;

endpackage

`default_nettype wire

>>> hdl/erba_ctrl.sv
`default_nettype none

module erba_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire erba_pkg::erba_stat_t stat,
    output erba_pkg::erba_cmd_t       cmd,
    output logic                      busy,
    output logic                      done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FRESH_RD,
        S_FRESH_CHK,
        S_GRANT_OLD,
        S_GRANT_NEW
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    // Sequence one request through check, scan, fresh take and grant
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.fin_status = erba_pkg::ST_GRANTED;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_size = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.size_zero)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = erba_pkg::ST_ZERO;
                    state_next     = S_IDLE;
                end
                else if (stat.size_big)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = erba_pkg::ST_TOOBIG;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    state_next = S_GRANT_OLD;
                end
                else if (stat.more)
                begin
                    cmd.issue = 1'b1;
                end
                else if (stat.pipe_empty)
                begin
                    if (stat.fresh_ok)
                    begin
                        state_next = S_FRESH_RD;
                    end
                    else
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = erba_pkg::ST_NOROOM;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_FRESH_RD:
            begin
                cmd.fresh_rd = 1'b1;
                state_next   = S_FRESH_CHK;
            end
            S_FRESH_CHK:
            begin
                if (stat.hit)
                begin
                    state_next = S_GRANT_NEW;
                end
                else
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = erba_pkg::ST_TOOBIG;
                    state_next     = S_IDLE;
                end
            end
            S_GRANT_OLD:
            begin
                cmd.grant  = 1'b1;
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            S_GRANT_NEW:
            begin
                cmd.grant     = 1'b1;
                cmd.grant_new = 1'b1;
                cmd.finish    = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
        done_next = cmd.finish;
    end

    // Hold state and the registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

>>> hdl/erba_datapath.sv
`default_nettype none

module erba_datapath
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire erba_pkg::erba_cmd_t                  cmd,
    output erba_pkg::erba_stat_t                      stat,
    input  wire logic [erba_pkg::BYTES_W-1:0]         request_bytes,
    input  wire logic                                 cfg_wr,
    input  wire logic [1:0]                           cfg_index,
    input  wire logic [erba_pkg::BYTES_W-1:0]         cfg_data,
    output logic [1:0]                                status,
    output logic [5:0]                                region_id,
    output logic [erba_pkg::OFFSET_BITS-1:0]          offset
);

    localparam int RB = erba_pkg::REGION_BITS;
    localparam int CB = erba_pkg::COUNT_BITS;
    localparam int BW = erba_pkg::BYTES_W;
    localparam int OW = erba_pkg::OBJ_W;
    localparam int SW = erba_pkg::CFG_SMALL_W;
    localparam int NR = erba_pkg::MAX_REGIONS;

    // Configuration
    logic [BW-1:0] region_bytes_reg;
    logic [SW-1:0] eden_limit_reg;

    // Allocator bookkeeping
    logic [CB-1:0] eden_count_reg;
    logic [RB-1:0] free_head_reg;
    logic [CB-1:0] free_count_reg;
    logic [NR-1:0] ent_vld_reg;

    // Region stores; per-region entries read as zero until valid
    logic [BW-1:0] used_mem_reg [NR];
    logic [OW-1:0] cnt_mem_reg  [NR];
    logic [RB-1:0] eden_mem_reg [NR];

    // Scan pipeline
    logic [BW-1:0] size_reg;
    logic [CB-1:0] idx_reg;
    logic          s1_vld_reg;
    logic [RB-1:0] s1_region_reg;
    logic          s2_vld_reg;
    logic [RB-1:0] s2_region_reg;
    logic [BW-1:0] s2_used_reg;
    logic [OW-1:0] s2_cnt_reg;
    logic          s2_ent_reg;

    logic [RB-1:0] rd_addr;
    logic          s2_load;
    logic [BW-1:0] used_eff;
    logic [OW-1:0] cnt_eff;
    logic          fit;
    logic          hit;
    logic          restart;
    logic [SW-1:0] riu_raw;
    logic [CB-1:0] riu_next;
    logic [RB-1:0] free_head_next;

    // Fit check on the region in the second stage
    assign used_eff = s2_ent_reg ? s2_used_reg : '0;
    assign cnt_eff  = s2_ent_reg ? s2_cnt_reg : '0;
    assign fit      = (used_eff < region_bytes_reg) &&
                      (size_reg <= (region_bytes_reg - used_eff));
    assign hit      = s2_vld_reg && fit;

    assign rd_addr = cmd.fresh_rd ? free_head_reg : s1_region_reg;
    assign s2_load = cmd.fresh_rd || (!hit && s1_vld_reg);

    assign restart  = cfg_wr && (cfg_index == erba_pkg::CFG_REGIONS_IN_USE);
    assign riu_raw  = cfg_data[SW-1:0];
    assign riu_next = (32'(riu_raw) > NR) ? CB'(NR) : CB'(riu_raw);

    assign free_head_next = (free_head_reg == RB'(NR - 1)) ? '0 : free_head_reg + 1'b1;

    // Report to the controller
    always_comb
    begin
        stat.size_zero  = (size_reg == '0);
        stat.size_big   = (size_reg > region_bytes_reg);
        stat.more       = (idx_reg < eden_count_reg);
        stat.pipe_empty = !s1_vld_reg && !s2_vld_reg;
        stat.hit        = hit;
        stat.fresh_ok   = (32'(eden_count_reg) < 32'(eden_limit_reg)) &&
                          (free_count_reg != '0) &&
                          (32'(eden_count_reg) < NR);
    end

    // Control state: configuration, counts, valid bits, pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_bytes_reg <= erba_pkg::RST_REGION_BYTES;
            eden_limit_reg   <= erba_pkg::RST_EDEN_LIMIT;
            eden_count_reg   <= '0;
            free_head_reg    <= '0;
            free_count_reg   <= (32'(erba_pkg::RST_REGIONS_IN_USE) > NR) ?
                                CB'(NR) : CB'(erba_pkg::RST_REGIONS_IN_USE);
            ent_vld_reg      <= '0;
            idx_reg          <= '0;
            s1_vld_reg       <= 1'b0;
            s2_vld_reg       <= 1'b0;
        end
        else
        begin
            // Take configuration writes; a region count write restarts
            if (cfg_wr && (cfg_index == erba_pkg::CFG_REGION_BYTES))
            begin
                region_bytes_reg <= cfg_data;
            end
            if (cfg_wr && (cfg_index == erba_pkg::CFG_EDEN_LIMIT))
            begin
                eden_limit_reg <= cfg_data[SW-1:0];
            end

            if (restart)
            begin
                eden_count_reg <= '0;
                free_head_reg  <= '0;
                free_count_reg <= riu_next;
                ent_vld_reg    <= '0;
            end
            else if (cmd.grant)
            begin
                ent_vld_reg[s2_region_reg] <= 1'b1;
                if (cmd.grant_new)
                begin
                    eden_count_reg <= eden_count_reg + 1'b1;
                    free_head_reg  <= free_head_next;
                    free_count_reg <= free_count_reg - 1'b1;
                end
            end

            // Advance the scan pipeline; freeze once a region fits
            if (cmd.scan_start)
            begin
                idx_reg    <= '0;
                s1_vld_reg <= 1'b0;
                s2_vld_reg <= 1'b0;
            end
            else if (!hit)
            begin
                s1_vld_reg <= cmd.issue;
                if (cmd.issue)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                s2_vld_reg <= cmd.fresh_rd || s1_vld_reg;
            end
        end
    end

    // Payload: request size, memory reads, pipeline data, result
    always_ff @(posedge clk)
    begin
        if (cmd.load_size)
        begin
            size_reg <= request_bytes;
        end
        if (cmd.issue && !hit)
        begin
            s1_region_reg <= eden_mem_reg[idx_reg[RB-1:0]];
        end
        if (s2_load)
        begin
            s2_region_reg <= rd_addr;
            s2_used_reg   <= used_mem_reg[rd_addr];
            s2_cnt_reg    <= cnt_mem_reg[rd_addr];
            s2_ent_reg    <= ent_vld_reg[rd_addr];
        end
        if (cmd.finish)
        begin
            status <= cmd.fin_status;
            if (cmd.grant)
            begin
                region_id <= 6'(s2_region_reg);
                offset    <= erba_pkg::OFFSET_BITS'(used_eff);
            end
            else
            begin
                region_id <= '0;
                offset    <= '0;
            end
        end
    end

    // Bump the fill level and object count, append fresh regions to eden
    always_ff @(posedge clk)
    begin
        if (cmd.grant)
        begin
            used_mem_reg[s2_region_reg] <= used_eff + size_reg;
            cnt_mem_reg[s2_region_reg]  <= cnt_eff + 1'b1;
            if (cmd.grant_new)
            begin
                eden_mem_reg[eden_count_reg[RB-1:0]] <= s2_region_reg;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/eden_region_bump_allocator.sv
// Region bump-pointer allocator for young objects.
// Request channel: drive request_bytes with start high; the request is taken
// at a rising edge where start is high and busy is low. busy stays high until
// the result is shown.
// Result channel: status, region_id and offset are valid for exactly one cycle
// while done is high; the receiver cannot stall, so the result must be taken
// then. busy is already low in that cycle, so the next request may be taken at
// the edge that ends it.
// Configuration: cfg_valid with cfg_index and cfg_data, cfg_ready always high;
// write only while idle. Index 0 region_bytes, 1 regions_in_use (restarts the
// allocator: eden list emptied, free queue refilled from region 0), 2
// eden_limit.
// A zero or oversized size ends after the check; otherwise the scan walks the
// eden list, and when no eden region fits and the eden limit and free queue
// allow, a fresh region is read and checked before the grant, else the result
// is no room. The scan reads one eden region per cycle through a two-stage
// read until a region fits.
// Reset loads the register defaults and an empty eden list; per-region fill
// levels are cleared at once by valid bits.
`default_nettype none

module eden_region_bump_allocator
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [erba_pkg::BYTES_W-1:0]         request_bytes,
    output logic                                      done,
    output logic [1:0]                                status,
    output logic [5:0]                                region_id,
    output logic [erba_pkg::OFFSET_BITS-1:0]          offset,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [1:0]                           cfg_index,
    input  wire logic [erba_pkg::BYTES_W-1:0]         cfg_data
);

    erba_pkg::erba_cmd_t  cmd;
    erba_pkg::erba_stat_t stat;
    logic                 cfg_wr;

    // Registers accept a write in any cycle
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    erba_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    erba_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .request_bytes (request_bytes),
        .cfg_wr        (cfg_wr),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .status        (status),
        .region_id     (region_id),
        .offset        (offset)
    );

endmodule

`default_nettype wire

>>> hdl/erba_checker.sv
`default_nettype none
`include "eden_region_bump_allocator_defines.svh"

module erba_checker
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic                                 busy,
    input  wire logic                                 done,
    input  wire logic [1:0]                           status,
    input  wire logic [5:0]                           region_id,
    input  wire logic [erba_pkg::OFFSET_BITS-1:0]     offset
);

    // An accepted transaction keeps the block busy
    `ERBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")

    // A result only follows a busy cycle and shows the block idle
    `ERBA_ASSERT_NOW(a_done_after_busy, done, !busy && $past(busy), "result without a busy transaction")

    // busy drops only together with a result
    `ERBA_ASSERT_NOW(a_fall_done, $fell(busy), done, "busy dropped without a result")

    // Failed transactions report region and offset as zero
    `ERBA_ASSERT_NOW(a_fail_zero, done && (status != erba_pkg::ST_GRANTED), (region_id == '0) && (offset == '0), "failed result carries region or offset")

endmodule

bind eden_region_bump_allocator erba_checker u_erba_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .region_id (region_id),
    .offset    (offset)
);

`default_nettype wire
